// ----- src/particle_pool_update_unit_macros.svh -----
// Assertion helpers for the particle pool update unit.
`ifndef PARTICLE_POOL_UPDATE_UNIT_MACROS_SVH
`define PARTICLE_POOL_UPDATE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PPU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("particle pool check failed");
`define PPU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("particle pool check failed");
`else
`define PPU_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PPU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- src/ppu_pkg.sv -----
`default_nettype none
package ppu_pkg;
    localparam int CAPACITY    = 64;
    localparam int MAX_READOUT = 64;
    localparam int FRAC_BITS   = 16;
    localparam int S_TDATA_W   = 336;
    localparam int M_TDATA_W   = 184;

    localparam logic [6:0]  LIMIT_RESET = 7'd64;
    localparam logic [16:0] RATIO_ONE   = 17'h10000;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [30:0] life;
        logic [30:0] full_life;
        logic [31:0] rotation;
        logic [31:0] spin;
        logic [30:0] scale;
        logic [47:0] color;
    } rec_t;
endpackage
`default_nettype wire

// ----- src/particle_pool_update_unit.sv -----
`default_nettype none
`include "particle_pool_update_unit_macros.svh"
// Particle pool in Q16.16: insert (mode 0) stores a particle if not full and returns one
// word; tick (mode 1) walks the pool in the record memory: read, check, multiply, write
// back each surviving particle; a removed one's slot is refilled from the tail and
// handled again, unless it is the tail. Readout (mode 2) returns one word per instance,
// set by the 16-step ratio divider and two multiply stages; the divider steps are skipped
// when the ratio is one or the full lifetime is zero. One item is in work at a time;
// a new one is taken while the last word is being taken. No clearing pass after reset.
module particle_pool_update_unit #(
    parameter int CAPACITY = ppu_pkg::CAPACITY
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [6:0]                      cfg_wr_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // pos_x, pos_y, vel_x, vel_y, lifetime, rotation, spin, size, color, step_time
    input  wire logic [ppu_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode
    input  wire logic [1:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // count, pos_x_out, pos_y_out, rotation_out, scale_out, color_out
    output logic [ppu_pkg::M_TDATA_W-1:0]        m_tdata,
    // accepted, valid_res
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NW = (CW > 7) ? CW : 7;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_T_RD   = 13'b0000000000010,
        S_T_EVAL = 13'b0000000000100,
        S_T_MOVE = 13'b0000000001000,
        S_T_MUL  = 13'b0000000010000,
        S_T_WB   = 13'b0000000100000,
        S_T_DONE = 13'b0000001000000,
        S_R_RD   = 13'b0000010000000,
        S_R_LOAD = 13'b0000100000000,
        S_R_DIV  = 13'b0001000000000,
        S_R_MUL1 = 13'b0010000000000,
        S_R_MUL2 = 13'b0100000000000,
        S_R_OUT  = 13'b1000000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [NW-1:0] n_reg, n_next;
    logic [6:0]    limit_reg, limit_next;
    logic          m_tvalid_reg, m_tvalid_next;

    logic [ppu_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]                    m_tuser_reg;
    logic                          m_tlast_reg;

    ppu_pkg::rec_t in_rec, rd_data, rec_reg, wb_rec, mem_wdata;
    logic [30:0]   dt_reg;
    logic [30:0]   life_new_reg;
    logic [AW-1:0] rd_addr, mem_waddr;
    logic          mem_we;

    logic          s_acc, out_free;
    logic [6:0]    lim7;
    logic [NW-1:0] cnt_ext, n_in;
    logic [31:0]   life_diff;
    logic          dead, is_last_slot;

    logic          div_start, div_done;
    logic [16:0]   div_quo, r_reg;

    logic signed [63:0] px, py, pr;
    logic signed [63:0] px_reg, py_reg, pr_reg;
    logic [47:0]   p_s1;
    logic [48:0]   p_s2;
    logic [32:0]   p_c0, p_c1, p_c2;
    logic [31:0]   s1_reg;
    logic [47:0]   col_reg;
    logic [30:0]   scl_reg;

    logic          out_load, o_acc, o_valid, o_last;
    logic [6:0]    o_count;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        in_rec.pos_x     = s_tdata[31:0];
        in_rec.pos_y     = s_tdata[63:32];
        in_rec.vel_x     = s_tdata[95:64];
        in_rec.vel_y     = s_tdata[127:96];
        in_rec.life      = s_tdata[158:128];
        in_rec.full_life = s_tdata[158:128];
        in_rec.rotation  = s_tdata[190:159];
        in_rec.spin      = s_tdata[222:191];
        in_rec.scale     = s_tdata[253:223];
        in_rec.color     = s_tdata[301:254];
    end

    assign lim7    = (limit_reg > 7'(ppu_pkg::MAX_READOUT)) ? 7'(ppu_pkg::MAX_READOUT)
                                                            : limit_reg;
    assign cnt_ext = NW'(count_reg);
    assign n_in    = (cnt_ext < NW'(lim7)) ? cnt_ext : NW'(lim7);

    assign life_diff    = {1'b0, rd_data.life} - {1'b0, dt_reg};
    assign dead         = life_diff[31] || (life_diff == '0);
    assign is_last_slot = (cnt_ext == idx_reg + NW'(1));

    // floor of the signed product over 2^16 is an arithmetic shift; keep 32 bits
    always_comb begin
        wb_rec          = rec_reg;
        wb_rec.life     = life_new_reg;
        wb_rec.pos_x    = rec_reg.pos_x + px_reg[47:16];
        wb_rec.pos_y    = rec_reg.pos_y + py_reg[47:16];
        wb_rec.rotation = rec_reg.rotation + pr_reg[47:16];
    end

    assign px   = $signed(rec_reg.vel_x) * $signed({1'b0, dt_reg});
    assign py   = $signed(rec_reg.vel_y) * $signed({1'b0, dt_reg});
    assign pr   = $signed(rec_reg.spin) * $signed({1'b0, dt_reg});
    assign p_s1 = 48'(rec_reg.scale) * 48'(r_reg);
    assign p_s2 = 49'(s1_reg) * 49'(r_reg);
    assign p_c0 = 33'(rec_reg.color[15:0]) * 33'(r_reg);
    assign p_c1 = 33'(rec_reg.color[31:16]) * 33'(r_reg);
    assign p_c2 = 33'(rec_reg.color[47:32]) * 33'(r_reg);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        limit_next    = cfg_wr_en ? cfg_wr_data : limit_reg;
        mem_we        = 1'b0;
        mem_waddr     = AW'(idx_reg);
        mem_wdata     = rd_data;
        rd_addr       = AW'(idx_reg);
        div_start     = 1'b0;
        out_load      = 1'b0;
        o_acc         = 1'b0;
        o_valid       = 1'b0;
        o_last        = 1'b1;
        o_count       = 7'(count_reg);
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    unique case (s_tuser)
                        ppu_pkg::MODE_INSERT: begin
                            out_load = 1'b1;
                            if (count_reg < CW'(CAPACITY)) begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = in_rec;
                                count_next = count_reg + CW'(1);
                                o_acc      = 1'b1;
                                o_count    = 7'(count_reg + CW'(1));
                            end
                        end
                        ppu_pkg::MODE_TICK: begin
                            idx_next   = '0;
                            state_next = S_T_RD;
                        end
                        ppu_pkg::MODE_READ: begin
                            if (n_in == '0) begin
                                out_load = 1'b1;
                            end else begin
                                n_next     = n_in;
                                idx_next   = '0;
                                state_next = S_R_RD;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_T_RD: begin
                state_next = (idx_reg >= cnt_ext) ? S_T_DONE : S_T_EVAL;
            end
            S_T_EVAL: begin
                if (dead) begin
                    count_next = count_reg - CW'(1);
                    if (is_last_slot) begin
                        state_next = S_T_RD;
                    end else begin
                        // fetch the tail record to fill this slot
                        rd_addr    = AW'(count_reg - CW'(1));
                        state_next = S_T_MOVE;
                    end
                end else begin
                    state_next = S_T_MUL;
                end
            end
            S_T_MOVE: begin
                mem_we     = 1'b1;
                state_next = S_T_RD;
            end
            S_T_MUL: begin
                state_next = S_T_WB;
            end
            S_T_WB: begin
                mem_we     = 1'b1;
                mem_wdata  = wb_rec;
                idx_next   = idx_reg + NW'(1);
                state_next = S_T_RD;
            end
            S_T_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_R_RD: begin
                state_next = S_R_LOAD;
            end
            S_R_LOAD: begin
                div_start  = 1'b1;
                state_next = S_R_DIV;
            end
            S_R_DIV: begin
                if (div_done) begin
                    state_next = S_R_MUL1;
                end
            end
            S_R_MUL1: begin
                state_next = S_R_MUL2;
            end
            S_R_MUL2: begin
                state_next = S_R_OUT;
            end
            S_R_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    o_valid    = 1'b1;
                    o_last     = (idx_reg + NW'(1) == n_reg);
                    idx_next   = idx_reg + NW'(1);
                    state_next = o_last ? S_IDLE : S_R_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            n_reg        <= '0;
            limit_reg    <= ppu_pkg::LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            n_reg        <= n_next;
            limit_reg    <= limit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            dt_reg <= s_tdata[332:302];
        end
        if (state_reg == S_T_EVAL || state_reg == S_R_LOAD) begin
            rec_reg      <= rd_data;
            life_new_reg <= life_diff[30:0];
        end
        if (state_reg == S_T_MUL) begin
            px_reg <= px;
            py_reg <= py;
            pr_reg <= pr;
        end
        if (div_done) begin
            r_reg <= div_quo;
        end
        if (state_reg == S_R_MUL1) begin
            s1_reg  <= p_s1[47:16];
            col_reg <= {p_c2[31:16], p_c1[31:16], p_c0[31:16]};
        end
        if (state_reg == S_R_MUL2) begin
            scl_reg <= p_s2[46:16];
        end
        if (out_load) begin
            m_tuser_reg <= {o_valid, o_acc};
            m_tlast_reg <= o_last;
            if (o_valid) begin
                m_tdata_reg <= {2'b00, col_reg, scl_reg, rec_reg.rotation,
                                rec_reg.pos_y, rec_reg.pos_x, o_count};
            end else begin
                m_tdata_reg <= {{(ppu_pkg::M_TDATA_W-7){1'b0}}, o_count};
            end
        end
    end

    ppu_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    ppu_div u_div (
        .clk   (aclk),
        .rstn  (aresetn),
        .start (div_start),
        .num   (rd_data.life),
        .den   (rd_data.full_life),
        .done  (div_done),
        .quo   (div_quo)
    );

    `PPU_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(CAPACITY))
    `PPU_ASSERT_IMPL(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `PPU_ASSERT_IMPL(a_div_in_wait, aclk, aresetn, div_done, state_reg == S_R_DIV)
    `PPU_ASSERT_IMPL(a_eval_in_pool, aclk, aresetn, state_reg == S_T_EVAL, idx_reg < cnt_ext)
    `PPU_ASSERT_NEXT(a_move_refills, aclk, aresetn, state_reg == S_T_MOVE, state_reg == S_T_RD)
endmodule
`default_nettype wire

// ----- src/ppu_mem.sv -----
`default_nettype none
module ppu_mem #(
    parameter int DEPTH = ppu_pkg::CAPACITY,
    parameter int AW    = 6
) (
    input  wire logic           clk,
    input  wire logic           we,
    input  wire logic [AW-1:0]  waddr,
    input  wire ppu_pkg::rec_t  wdata,
    input  wire logic [AW-1:0]  raddr,
    output ppu_pkg::rec_t       rdata
);
    ppu_pkg::rec_t mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- src/ppu_div.sv -----
`default_nettype none
// Life ratio: floor(num * 2^16 / den), clamped to one, zero for a zero divisor.
module ppu_div (
    input  wire logic        clk,
    input  wire logic        rstn,
    input  wire logic        start,
    input  wire logic [30:0] num,
    input  wire logic [30:0] den,
    output logic             done,
    output logic [16:0]      quo
);
    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [16:0] quo_reg;
    logic [31:0] rem_dbl;
    logic        q_bit;

    assign rem_dbl = {rem_reg[30:0], 1'b0};
    assign q_bit   = rem_dbl >= {1'b0, den};
    assign done    = done_reg;
    assign quo     = quo_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (den == '0 || num >= den) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 5'(ppu_pkg::FRAC_BITS);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= {1'b0, num};
            if (den == '0) begin
                quo_reg <= '0;
            end else if (num >= den) begin
                quo_reg <= ppu_pkg::RATIO_ONE;
            end else begin
                quo_reg <= '0;
            end
        end else if (busy_reg) begin
            rem_reg <= q_bit ? rem_dbl - {1'b0, den} : rem_dbl;
            quo_reg <= {quo_reg[15:0], q_bit};
        end
    end
endmodule
`default_nettype wire
